/* design/jlsr_pkg.sv */
// Shared types, register map and constants for the jerk-limited speed ramp.
// No dependencies; imported by every module of the block.
package jlsr_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int CFG_IW  = CFG_AW - 2;
  localparam int LIM_W   = 31;

  localparam logic [CFG_IW-1:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ACCEL_LIMIT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DECEL_LIMIT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_JERK_LIMIT  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SYNC_TOL    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TICK_PERIOD = 3'd5;

  localparam logic [LIM_W-1:0] RST_SPEED_LIMIT = 31'd65536;
  localparam logic [LIM_W-1:0] RST_ACCEL_LIMIT = 31'd32768;
  localparam logic [LIM_W-1:0] RST_DECEL_LIMIT = 31'd32768;
  localparam logic [LIM_W-1:0] RST_JERK_LIMIT  = 31'd65536;
  localparam logic [LIM_W-1:0] RST_SYNC_TOL    = 31'd6554;
  localparam logic [LIM_W-1:0] RST_TICK_PERIOD = 31'd3277;

  typedef struct packed {
    logic signed [31:0] req_speed;
    logic signed [31:0] fb_speed;
  } jlsr_in_t;

  typedef struct packed {
    logic [30:0]        command_speed;
    logic signed [31:0] command_accel;
    logic signed [31:0] command_jerk;
    logic               override_flag;
    logic               hold_flag;
    logic               input_error;
  } jlsr_out_t;

  typedef struct packed {
    logic [LIM_W-1:0] speed_limit;
    logic [LIM_W-1:0] accel_limit;
    logic [LIM_W-1:0] decel_limit;
    logic [LIM_W-1:0] jerk_limit;
    logic [LIM_W-1:0] sync_tolerance;
    logic [LIM_W-1:0] tick_period;
  } jlsr_cfg_t;

  typedef enum logic {
    NUM_ACC = 1'b0,
    NUM_JRK = 1'b1
  } jlsr_num_sel_t;

  typedef struct packed {
    logic          load;
    logic          prep;
    logic          num_load;
    jlsr_num_sel_t num_sel;
    logic          div_start;
    logic          bounds;
    logic          want_take;
    logic          ca;
    logic          mul_ca;
    logic          unc;
    logic          spd;
    logic          acc_take;
    logic          commit;
    logic          out_load;
  } jlsr_cmd_t;

  typedef struct packed {
    logic err;
    logic div_done;
    logic out_free;
  } jlsr_sts_t;

endpackage

/* design/jlsr_regs.sv */
// APB-style configuration register block for the speed ramp limits.
// Depends on jlsr_pkg for the register map, reset values and jlsr_cfg_t.
module jlsr_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jlsr_pkg::CFG_AW-1:0] paddr,
  input  logic [jlsr_pkg::CFG_DW-1:0] pwdata,
  output logic [jlsr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output jlsr_pkg::jlsr_cfg_t         cfg
);
  import jlsr_pkg::*;

  jlsr_cfg_t         cfg_r;
  jlsr_cfg_t         cfg_nxt;
  logic              wr_en;
  logic [CFG_IW-1:0] idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SPEED_LIMIT: cfg_nxt.speed_limit    = pwdata[LIM_W-1:0];
        REG_ACCEL_LIMIT: cfg_nxt.accel_limit    = pwdata[LIM_W-1:0];
        REG_DECEL_LIMIT: cfg_nxt.decel_limit    = pwdata[LIM_W-1:0];
        REG_JERK_LIMIT:  cfg_nxt.jerk_limit     = pwdata[LIM_W-1:0];
        REG_SYNC_TOL:    cfg_nxt.sync_tolerance = pwdata[LIM_W-1:0];
        REG_TICK_PERIOD: cfg_nxt.tick_period    = pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_LIMIT: prdata = {1'b0, cfg_r.speed_limit};
      REG_ACCEL_LIMIT: prdata = {1'b0, cfg_r.accel_limit};
      REG_DECEL_LIMIT: prdata = {1'b0, cfg_r.decel_limit};
      REG_JERK_LIMIT:  prdata = {1'b0, cfg_r.jerk_limit};
      REG_SYNC_TOL:    prdata = {1'b0, cfg_r.sync_tolerance};
      REG_TICK_PERIOD: prdata = {1'b0, cfg_r.tick_period};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit    <= RST_SPEED_LIMIT;
      cfg_r.accel_limit    <= RST_ACCEL_LIMIT;
      cfg_r.decel_limit    <= RST_DECEL_LIMIT;
      cfg_r.jerk_limit     <= RST_JERK_LIMIT;
      cfg_r.sync_tolerance <= RST_SYNC_TOL;
      cfg_r.tick_period    <= RST_TICK_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/jlsr_div.sv */
// Radix-2 restoring divider: signed numerator / unsigned period in Q16.16,
// truncated toward zero, saturated to VB bits. Depends on jlsr_pkg.
module jlsr_div #(
  parameter int VB = jlsr_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [((VB > 32) ? VB : 32)+1:0] num,
  input  logic [jlsr_pkg::LIM_W-1:0]             den,
  output logic                                   done,
  output logic signed [VB-1:0]                   quo
);
  import jlsr_pkg::*;

  localparam int WIDE = (VB > 32) ? VB : 32;
  localparam int NUMW = WIDE + 2;
  localparam int MAGW = WIDE + 1;
  localparam int DW   = MAGW + 16;
  localparam int QW   = VB;
  localparam int TW   = DW - QW;
  localparam int RMW  = (TW > 32) ? TW : 32;
  localparam int CW   = $clog2(QW);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_CHECK = 4'b0010,
    D_STEP  = 4'b0100,
    D_FIN   = 4'b1000
  } div_state_t;

  div_state_t          st_r, st_nxt;
  logic [CW-1:0]       cnt_r;
  logic                done_r;
  logic                neg_r, zero_r, ovf_r;
  logic [RMW-1:0]      top_r;
  logic [QW-1:0]       low_r;
  logic signed [VB-1:0] quo_r;

  logic [NUMW-1:0]     num_abs;
  logic [MAGW-1:0]     mag;
  logic [DW-1:0]       dvd;
  logic                ovf_nxt;
  logic [31:0]         trial;
  logic [31:0]         den_x;
  logic [31:0]         diff;
  logic                ge;
  logic signed [VB-1:0] res_nxt;
  logic [VB-1:0]       qmax, qmin;

  assign num_abs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign mag     = num_abs[MAGW-1:0];
  assign dvd     = {mag, 16'h0000};
  // quotient no smaller than 2^QW when the top part already reaches den
  assign ovf_nxt = top_r >= RMW'(den);

  assign den_x = {1'b0, den};
  assign trial = {top_r[30:0], low_r[QW-1]};
  assign ge    = trial >= den_x;
  assign diff  = trial - den_x;

  assign qmax = {1'b0, {(VB-1){1'b1}}};
  assign qmin = {1'b1, {(VB-1){1'b0}}};

  always_comb begin
    if (zero_r) begin
      res_nxt = '0;
    end else if (ovf_r) begin
      res_nxt = neg_r ? $signed(qmin) : $signed(qmax);
    end else if (!neg_r) begin
      res_nxt = low_r[VB-1] ? $signed(qmax) : $signed(low_r);
    end else if (low_r[VB-1] && (low_r[VB-2:0] != '0)) begin
      res_nxt = $signed(qmin);
    end else begin
      res_nxt = $signed(-low_r);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE:  if (start) st_nxt = D_CHECK;
      D_CHECK: st_nxt = (zero_r || ovf_nxt) ? D_FIN : D_STEP;
      D_STEP:  if (cnt_r == CW'(QW - 1)) st_nxt = D_FIN;
      D_FIN:   st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == D_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      D_IDLE: begin
        if (start) begin
          neg_r  <= num[NUMW-1];
          zero_r <= (mag == '0);
          top_r  <= RMW'(dvd[DW-1:QW]);
          low_r  <= dvd[QW-1:0];
        end
      end
      D_CHECK: begin
        ovf_r <= ovf_nxt;
        cnt_r <= '0;
      end
      D_STEP: begin
        top_r <= RMW'(ge ? diff : trial);
        low_r <= {low_r[QW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      D_FIN: quo_r <= res_nxt;
      default: ;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* design/jlsr_dp.sv */
// Datapath of the speed ramp: held state, bound and clamp logic, shared
// multiplier, divider instance and output register. Depends on jlsr_pkg, jlsr_div.
module jlsr_dp #(
  parameter int VB = jlsr_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jlsr_pkg::jlsr_cfg_t  cfg,
  input  jlsr_pkg::jlsr_in_t   in_data,
  input  jlsr_pkg::jlsr_cmd_t  cmd,
  output jlsr_pkg::jlsr_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jlsr_pkg::jlsr_out_t  out_data
);
  import jlsr_pkg::*;

  localparam int WIDE = (VB > 32) ? VB : 32;
  localparam int NUMW = WIDE + 2;
  localparam int CMPW = WIDE + 1;
  localparam int BNDW = 48;
  localparam int UNCW = 49;

  // held state
  logic                    started_r;
  logic [30:0]             held_speed_r;
  logic signed [31:0]      held_accel_r;
  logic                    override_r;

  // per-transaction working registers
  logic [30:0]             tgt_r, meas_r;
  logic                    err_r, fb_r, rec_r, inst_r;
  logic signed [NUMW-1:0]  num_r;
  logic signed [63:0]      prod_r;
  logic signed [BNDW-1:0]  lo_r, hi_r;
  logic signed [31:0]      want_r, ca_r;
  logic signed [UNCW-1:0]  unc_r;
  logic [30:0]             spd_r;
  logic signed [VB-1:0]    acc_r, jrk_r;
  logic                    out_valid_r;
  jlsr_out_t               out_r;

  logic                    div_done;
  logic signed [VB-1:0]    div_quo;

  jlsr_div #(.VB(VB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (cfg.tick_period),
    .done  (div_done),
    .quo   (div_quo)
  );

  // input capture
  logic        in_err;
  logic [30:0] in_tgt_cap, in_meas_clip;
  assign in_err       = in_data.req_speed[31];
  assign in_tgt_cap   = (in_data.req_speed[30:0] > cfg.speed_limit) ?
                        cfg.speed_limit : in_data.req_speed[30:0];
  assign in_meas_clip = in_data.fb_speed[31] ? '0 : in_data.fb_speed[30:0];

  // feedback hold and first numerator
  logic [31:0]            meas_tol;
  logic                   fb_nxt;
  logic signed [NUMW-1:0] want_num, acc_num, jrk_num, num_nxt;
  assign meas_tol = {1'b0, meas_r} + {1'b0, cfg.sync_tolerance};
  assign fb_nxt   = (tgt_r > held_speed_r) && ({1'b0, held_speed_r} > meas_tol);
  assign want_num = fb_nxt ? '0 :
                    NUMW'($signed({1'b0, tgt_r}) - $signed({1'b0, held_speed_r}));
  assign acc_num  = NUMW'($signed({1'b0, spd_r}) - $signed({1'b0, held_speed_r}));
  assign jrk_num  = NUMW'(acc_r) - NUMW'(held_accel_r);
  assign num_nxt  = (cmd.num_sel == NUM_JRK) ? jrk_num : acc_num;

  // shared multiplier: jerk step first, then ca * period
  logic signed [31:0] mul_a, mul_b;
  assign mul_a = cmd.mul_ca ? ca_r : $signed({1'b0, cfg.jerk_limit});
  assign mul_b = $signed({1'b0, cfg.tick_period});

  // jerk window
  logic signed [BNDW-1:0] js_b, pa_b, lo_raw, hi_raw, dneg_b, amax_b, lo_nxt, hi_nxt;
  assign js_b   = $signed({2'b00, prod_r[61:16]});
  assign pa_b   = BNDW'(held_accel_r);
  assign lo_raw = pa_b - js_b;
  assign hi_raw = pa_b + js_b;
  assign dneg_b = -$signed({{(BNDW-LIM_W){1'b0}}, cfg.decel_limit});
  assign amax_b = $signed({{(BNDW-LIM_W){1'b0}}, cfg.accel_limit});
  assign lo_nxt = (lo_raw < dneg_b) ? dneg_b : lo_raw;
  assign hi_nxt = (hi_raw > amax_b) ? amax_b : hi_raw;

  // clamps to the acceleration limits
  logic signed [CMPW-1:0] dneg_c, amax_c, quo_c, acc_c, want_nxt, hacc_c;
  assign dneg_c   = -$signed({{(CMPW-LIM_W){1'b0}}, cfg.decel_limit});
  assign amax_c   = $signed({{(CMPW-LIM_W){1'b0}}, cfg.accel_limit});
  assign quo_c    = CMPW'(div_quo);
  assign acc_c    = CMPW'(acc_r);
  assign want_nxt = (quo_c < dneg_c) ? dneg_c : ((quo_c > amax_c) ? amax_c : quo_c);
  assign hacc_c   = (acc_c < dneg_c) ? dneg_c : ((acc_c > amax_c) ? amax_c : acc_c);

  // lower bound tested first, as when the window is inverted
  logic signed [BNDW-1:0] want_b, ca_full;
  assign want_b  = BNDW'(want_r);
  assign ca_full = (want_b < lo_r) ? lo_r : ((hi_r < want_b) ? hi_r : want_b);

  // integrate: product / 65536 truncated toward zero
  logic signed [UNCW-1:0] pv_u, prod_fl, rnd_s, unc_nxt;
  logic                   round_up;
  assign pv_u     = {{(UNCW-31){1'b0}}, held_speed_r};
  assign prod_fl  = UNCW'(prod_r >>> 16);
  assign round_up = prod_r[63] && (prod_r[15:0] != '0);
  assign rnd_s    = {{(UNCW-1){1'b0}}, round_up};
  assign unc_nxt  = pv_u + prod_fl + rnd_s;

  // zero clip and upper cap
  logic signed [UNCW-1:0] shaped, tgt_u;
  logic                   upper;
  assign shaped = unc_r[UNCW-1] ? '0 : unc_r;
  assign tgt_u  = {{(UNCW-31){1'b0}}, tgt_r};
  assign upper  = tgt_u < shaped;

  // result assembly
  logic signed [WIDE-1:0] acc_w, jrk_w;
  jlsr_out_t              res;
  assign acc_w = WIDE'(acc_r);
  assign jrk_w = WIDE'(jrk_r);

  always_comb begin
    res = '0;
    if (err_r) begin
      res.input_error = 1'b1;
    end else begin
      res.command_speed = spd_r;
      res.command_accel = acc_w[31:0];
      res.command_jerk  = jrk_w[31:0];
      res.override_flag = inst_r | rec_r;
      res.hold_flag     = fb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      held_speed_r <= '0;
      held_accel_r <= '0;
      override_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load && !in_err && !started_r) begin
        started_r    <= 1'b1;
        held_speed_r <= in_meas_clip;
        held_accel_r <= '0;
      end
      if (cmd.commit) begin
        held_speed_r <= spd_r;
        held_accel_r <= (spd_r == '0) ? '0 : $signed(hacc_c[31:0]);
        override_r   <= inst_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r  <= in_tgt_cap;
      meas_r <= in_meas_clip;
      err_r  <= in_err;
    end
    if (cmd.prep) begin
      fb_r  <= fb_nxt;
      rec_r <= override_r;
      num_r <= want_num;
    end
    if (cmd.num_load) num_r <= num_nxt;
    if (cmd.prep || cmd.mul_ca) prod_r <= mul_a * mul_b;
    if (cmd.bounds) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.want_take) want_r <= $signed(want_nxt[31:0]);
    if (cmd.ca)        ca_r   <= $signed(ca_full[31:0]);
    if (cmd.unc)       unc_r  <= unc_nxt;
    if (cmd.spd) begin
      spd_r  <= upper ? tgt_r : shaped[30:0];
      inst_r <= upper || unc_r[UNCW-1];
    end
    if (cmd.acc_take) acc_r <= div_quo;
    if (cmd.commit)   jrk_r <= div_quo;
    if (cmd.out_load) out_r <= res;
  end

  assign sts.err      = err_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

/* design/jlsr_ctrl.sv */
// Sequencer for one speed-ramp transaction: issues datapath commands and
// waits on divider completion and output-register space. Depends on jlsr_pkg.
module jlsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jlsr_pkg::jlsr_sts_t sts,
  output jlsr_pkg::jlsr_cmd_t cmd
);
  import jlsr_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_CHECK  = 15'b000000000000010,
    ST_WSTART = 15'b000000000000100,
    ST_WWAIT  = 15'b000000000001000,
    ST_CA     = 15'b000000000010000,
    ST_MUL    = 15'b000000000100000,
    ST_UNC    = 15'b000000001000000,
    ST_SPD    = 15'b000000010000000,
    ST_ANUM   = 15'b000000100000000,
    ST_ASTART = 15'b000001000000000,
    ST_AWAIT  = 15'b000010000000000,
    ST_JNUM   = 15'b000100000000000,
    ST_JSTART = 15'b001000000000000,
    ST_JWAIT  = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // negative target skips all arithmetic and leaves state alone
        if (sts.err) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_WSTART;
        end
      end
      ST_WSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WWAIT;
      end
      ST_WWAIT: begin
        cmd.bounds = 1'b1;
        if (sts.div_done) begin
          cmd.want_take = 1'b1;
          state_nxt     = ST_CA;
        end
      end
      ST_CA: begin
        cmd.ca    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_ca = 1'b1;
        state_nxt  = ST_UNC;
      end
      ST_UNC: begin
        cmd.unc   = 1'b1;
        state_nxt = ST_SPD;
      end
      ST_SPD: begin
        cmd.spd   = 1'b1;
        state_nxt = ST_ANUM;
      end
      ST_ANUM: begin
        cmd.num_load = 1'b1;
        cmd.num_sel  = NUM_ACC;
        state_nxt    = ST_ASTART;
      end
      ST_ASTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_AWAIT;
      end
      ST_AWAIT: begin
        if (sts.div_done) begin
          cmd.acc_take = 1'b1;
          state_nxt    = ST_JNUM;
        end
      end
      ST_JNUM: begin
        cmd.num_load = 1'b1;
        cmd.num_sel  = NUM_JRK;
        state_nxt    = ST_JSTART;
      end
      ST_JSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_JWAIT;
      end
      ST_JWAIT: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/jerk_limited_speed_ramp_core.sv */
// Jerk-limited speed ramp, signed Q16.16. A negative target skips all arithmetic and goes
// straight to the output register; other transactions run three divisions on the shared
// divider, one quotient bit per cycle, and a zero numerator or a saturating quotient ends
// a division before its bit steps. One transaction at a time: the next input is taken the
// cycle after the result is loaded, so a new item is not taken before the last is through;
// a result not taken by out_ready holds the sequencer until the output register frees.
// Synchronous active-low reset clears the held state and restores register defaults.
module jerk_limited_speed_ramp_core #(
  parameter int VALUE_BITS = jlsr_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  jlsr_pkg::jlsr_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output jlsr_pkg::jlsr_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jlsr_pkg::CFG_AW-1:0] paddr,
  input  logic [jlsr_pkg::CFG_DW-1:0] pwdata,
  output logic [jlsr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import jlsr_pkg::*;

  jlsr_cfg_t cfg;
  jlsr_cmd_t cmd;
  jlsr_sts_t sts;

  jlsr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jlsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jlsr_dp #(.VB(VALUE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for the jerk-limited speed ramp core: APB register
// phases, randomised valid/ready traffic and a Q16.16 predictor of the ramp.
// Depends on design/jlsr_pkg.sv and design/jerk_limited_speed_ramp_core.sv.
`timescale 1ns / 1ps

module testbench;
  import jlsr_pkg::*;

  localparam longint WORD_MAX   = (64'sd1 <<< (VALUE_BITS_DEF - 1)) - 1;
  localparam longint WORD_MIN   = -WORD_MAX - 1;
  localparam longint unsigned DIV_CAP = 64'd1 << 62;
  localparam int     CYCLE_LIMIT = 1_000_000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  jlsr_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  jlsr_out_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  jerk_limited_speed_ramp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and held state
  longint lim_speed = RST_SPEED_LIMIT, lim_accel = RST_ACCEL_LIMIT;
  longint lim_decel = RST_DECEL_LIMIT, lim_jerk = RST_JERK_LIMIT;
  longint lim_tol = RST_SYNC_TOL, lim_tick = RST_TICK_PERIOD;
  bit     primed = 1'b0, override_q = 1'b0;
  longint cmd_speed_q = 0, cmd_accel_q = 0;

  jlsr_in_t  pending_items[$];
  jlsr_out_t expected_results[$];
  jlsr_out_t oldest;
  jlsr_out_t predicted;

  bit     steady = 1'b1;
  longint ramp_goal = 0;
  int     send_gap = 0, hold_off = 0;
  int     cycle_count = 0, mismatches = 0;
  int     n_items = 0, n_rejected = 0, n_held = 0, n_override = 0, n_settings = 1;

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (hi < v) return hi;
    return v;
  endfunction

  // Q16.16 quotient, truncated toward zero; divide by zero saturates by sign
  function automatic longint q16_div(longint num, longint unsigned den);
    longint unsigned mag, quo, rem, res;
    if (num == 0) return 0;
    mag = (num < 0) ? -num : num;
    if (den == 0) begin
      res = DIV_CAP;
    end else begin
      quo = mag / den;
      rem = mag % den;
      res = (quo >= (64'd1 << 46)) ? DIV_CAP : (quo << 16) + (rem << 16) / den;
    end
    if (res > DIV_CAP) res = DIV_CAP;
    return sat_word((num < 0) ? -longint'(res) : longint'(res));
  endfunction

  function automatic jlsr_out_t ramp_predict(jlsr_in_t item);
    longint tgt, meas, amax, dmax, tp, pv, pa, want, step, lo, hi, ca, unc;
    longint shaped, spd, acc, jrk;
    bit prev_ovr, hold, capped;
    jlsr_out_t res;
    res = '0;
    tgt = item.req_speed;
    meas = item.fb_speed;
    if (tgt < 0) begin
      res.input_error = 1'b1;
      return res;
    end
    amax = lim_accel;
    dmax = lim_decel;
    tp = lim_tick;
    if (tgt > lim_speed) tgt = lim_speed;
    if (meas < 0) meas = 0;
    if (!primed) begin
      primed = 1'b1;
      cmd_speed_q = meas;
      cmd_accel_q = 0;
    end
    prev_ovr = override_q;
    pv = cmd_speed_q;
    pa = cmd_accel_q;
    // command rising but already ahead of feedback: aim at itself
    hold = (tgt > pv) && (pv > meas + lim_tol);
    want = clip(q16_div((hold ? pv : tgt) - pv, tp), -dmax, amax);
    step = (lim_jerk * tp) >> 16;
    lo = pa - step;
    if (lo < -dmax) lo = -dmax;
    hi = pa + step;
    if (hi > amax) hi = amax;
    ca = clip(want, lo, hi);
    unc = pv + (ca * tp) / 65536;
    shaped = (unc < 0) ? 0 : unc;
    spd = (shaped < tgt) ? shaped : tgt;
    capped = (tgt < shaped) || (unc < 0);
    acc = q16_div(spd - pv, tp);
    jrk = q16_div(acc - pa, tp);
    cmd_speed_q = spd;
    cmd_accel_q = (spd <= 0) ? 0 : clip(acc, -dmax, amax);
    override_q = capped;
    res.command_speed = spd[30:0];
    res.command_accel = acc[31:0];
    res.command_jerk = jrk[31:0];
    res.override_flag = capped || prev_ovr;
    res.hold_flag = hold;
    return res;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(99, 0);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic longint rand_upto(longint n);
    if (n <= 0) return 0;
    if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
    return $urandom_range(n[31:0], 0);
  endfunction

  // register value spread over many magnitudes, zero now and then
  function automatic logic [31:0] rand_reg();
    return ($urandom() & 32'h7FFF_FFFF) >> $urandom_range(24, 0);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // sender: next item once the previous transaction has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= steady ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted = ramp_predict(in_data);
      expected_results = {expected_results, predicted};
      n_items++;
      n_rejected += predicted.input_error;
      n_held += predicted.hold_flag;
      n_override += predicted.override_flag;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off <= 0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!steady && $urandom_range(99, 0) < 20) begin
      out_ready <= 1'b0;
      hold_off <= idle_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result (command_speed)", '0, out_data.command_speed);
      end else begin
        oldest = expected_results.pop_front();
        if (out_data.command_speed !== oldest.command_speed)
          flag_mismatch("command_speed", oldest.command_speed, out_data.command_speed);
        if (out_data.command_accel !== oldest.command_accel)
          flag_mismatch("command_accel", oldest.command_accel, out_data.command_accel);
        if (out_data.command_jerk !== oldest.command_jerk)
          flag_mismatch("command_jerk", oldest.command_jerk, out_data.command_jerk);
        if (out_data.override_flag !== oldest.override_flag)
          flag_mismatch("override_flag", oldest.override_flag, out_data.override_flag);
        if (out_data.hold_flag !== oldest.hold_flag)
          flag_mismatch("hold_flag", oldest.hold_flag, out_data.hold_flag);
        if (out_data.input_error !== oldest.input_error)
          flag_mismatch("input_error", oldest.input_error, out_data.input_error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(longint t, longint m);
    jlsr_in_t item;
    t = sat_word(t);
    m = sat_word(m);
    item.req_speed = t[31:0];
    item.fb_speed = m[31:0];
    pending_items = {pending_items, item};
  endtask

  // sampled on the falling edge so every handshake of the cycle has settled
  task automatic wait_drained(int tail);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPEED_LIMIT: lim_speed = value[30:0];
      REG_ACCEL_LIMIT: lim_accel = value[30:0];
      REG_DECEL_LIMIT: lim_decel = value[30:0];
      REG_JERK_LIMIT:  lim_jerk  = value[30:0];
      REG_SYNC_TOL:    lim_tol   = value[30:0];
      REG_TICK_PERIOD: lim_tick  = value[30:0];
      default: ;
    endcase
  endtask

  // mostly a held goal with feedback tracking or lagging the command, plus noise
  task automatic queue_random(int n);
    longint tgt, meas;
    int pick;
    for (int k = 0; k < n; k++) begin
      while (pending_items.size() >= 2) @(negedge clk);
      if ($urandom_range(99, 0) < 15) ramp_goal = rand_upto(lim_speed + lim_speed / 4);
      pick = $urandom_range(99, 0);
      if (pick < 8)       tgt = -longint'($urandom_range(32'h8000_0000, 1));
      else if (pick < 16) tgt = longint'($signed($urandom()));
      else if (pick < 24) tgt = 0;
      else                tgt = ramp_goal;
      pick = $urandom_range(99, 0);
      if (pick < 45)      meas = cmd_speed_q - lim_tol + rand_upto(2 * lim_tol);
      else if (pick < 70) meas = cmd_speed_q - lim_tol - 1 - rand_upto(4 * lim_tol);
      else if (pick < 80) meas = 0;
      else if (pick < 88) meas = -longint'($urandom_range(32'h8000_0000, 1));
      else                meas = longint'($signed($urandom()));
      push_item(tgt, meas);
    end
  endtask

  task automatic run_phase(logic [31:0] sp, logic [31:0] ac, logic [31:0] dc,
                           logic [31:0] jk, logic [31:0] tol, logic [31:0] tp, int n);
    wait_drained(8);
    write_reg(REG_SPEED_LIMIT, sp);
    write_reg(REG_ACCEL_LIMIT, ac);
    write_reg(REG_DECEL_LIMIT, dc);
    write_reg(REG_JERK_LIMIT, jk);
    write_reg(REG_SYNC_TOL, tol);
    write_reg(REG_TICK_PERIOD, tp);
    n_settings++;
    steady = ($urandom_range(3, 0) == 0);
    queue_random(n);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // rejected targets ahead of the first tick must not load the command
    push_item(-1, 1000);
    push_item(WORD_MIN, WORD_MAX);
    // first tick: capped target, negative feedback taken as zero
    push_item(WORD_MAX, WORD_MIN);
    // ramp with feedback stuck at zero until the lead hold kicks in
    repeat (12) push_item(65536, 0);
    // target dropped to zero: cap override, then the flag's one-tick echo
    repeat (3) push_item(0, 0);
    push_item(32768, 32768);
    push_item(WORD_MAX, WORD_MAX);
    push_item(0, -1);
    wait_drained(8);

    steady = 1'b0;
    queue_random(110);
    run_phase('1, '1, '1, '1, '1, '1, 60);
    run_phase(1, 1, 1, 1, 1, 1, 60);
    run_phase(32'h0100_0000, 32'h0080_0000, 32'h0080_0000, 32'h0400_0000,
              32'h0002_0000, 3277, 110);
    // far tighter limits while the held acceleration is still large
    run_phase(32'h0100_0000, 200, 300, 50, 32'h0002_0000, 3277, 80);
    run_phase(65536, 32768, 32768, 65536, 6554, 0, 60);
    run_phase(65536, 0, 0, 0, 0, 3277, 40);
    repeat (3)
      run_phase(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                $urandom_range(131072, 1), 90);

    wait_drained(130);
    if (expected_results.size() != 0)
      flag_mismatch("results never delivered", expected_results.size(), '0);
    $display("%0d transactions over %0d register settings: %0d negative targets,",
             n_items, n_settings, n_rejected);
    $display("%0d feedback holds, %0d override flags, %0d cycles", n_held, n_override,
             cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
